### rtl/core/ttw_pkg.sv
package ttw_pkg;

    localparam int CMD_W      = 2;
    localparam int ID_W       = 6;
    localparam int TIMEOUT_W  = 16;
    localparam int ROUNDS_W   = 8;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 8;

    localparam int DEF_NUM_SLOTS  = 256;
    localparam int DEF_MAX_TIMERS = 64;

    localparam logic [CMD_W-1:0] CMD_ADD     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REFRESH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CANCEL  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd3;

    localparam logic [ROUNDS_W-1:0] ROUNDS_MAX = '1;

endpackage

### rtl/core/ttw_ram.sv
module ttw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                      aclk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [WIDTH-1:0]          wdata,
    input  logic                      re,
    input  logic [AW-1:0]             raddr,
    output logic [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/ttw_div.sv
module ttw_div #(
    parameter int DIVISOR = ttw_pkg::DEF_NUM_SLOTS,
    parameter int SLOT_W  = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [ttw_pkg::TIMEOUT_W-1:0] dividend,
    output logic                          done,
    output logic [ttw_pkg::TIMEOUT_W-1:0] quot,
    output logic [SLOT_W-1:0]             rem
);

    localparam int TW      = ttw_pkg::TIMEOUT_W;
    localparam int SHIFT   = TW + SLOT_W;
    localparam int RECIP_W = TW + 2;
    localparam int PROD_W  = TW + RECIP_W;

    // ceil(2^SHIFT / DIVISOR) gives an exact quotient for every TW-bit dividend
    localparam longint RECIP_L = ((longint'(1) << SHIFT) + longint'(DIVISOR) - 1)
                                 / longint'(DIVISOR);
    localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP_L);
    localparam logic [TW-1:0]      DIV_TW  = TW'(DIVISOR);
    localparam logic [SLOT_W:0]    DIV_V   = (SLOT_W+1)'(DIVISOR);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_BACK = 2'd2;
    localparam logic [1:0] PH_SUB  = 2'd3;

    logic [1:0]        phase_reg, phase_next;
    logic              done_reg, done_next;
    logic [TW-1:0]     num_reg, num_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [TW-1:0]     quot_reg, quot_next;
    logic [TW-1:0]     back_reg, back_next;
    logic [SLOT_W-1:0] rem_reg, rem_next;
    logic [TW-1:0]     q_shift;

    // reciprocal multiply, back multiply, subtract: one step per cycle
    assign q_shift = TW'(prod_reg >> SHIFT);

    always_comb begin
        phase_next = phase_reg;
        done_next  = 1'b0;
        num_next   = num_reg;
        prod_next  = prod_reg;
        quot_next  = quot_reg;
        back_next  = back_reg;
        rem_next   = rem_reg;
        unique case (phase_reg)
            PH_IDLE: begin
                if (start) begin
                    num_next   = dividend;
                    phase_next = PH_MUL;
                end
            end
            PH_MUL: begin
                prod_next  = {{RECIP_W{1'b0}}, num_reg} * {{TW{1'b0}}, RECIP_V};
                phase_next = PH_BACK;
            end
            PH_BACK: begin
                quot_next  = q_shift;
                back_next  = q_shift * DIV_TW;
                phase_next = PH_SUB;
            end
            PH_SUB: begin
                rem_next   = SLOT_W'(num_reg - back_reg);
                done_next  = 1'b1;
                phase_next = PH_IDLE;
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
        num_reg  <= num_next;
        prod_reg <= prod_next;
        quot_reg <= quot_next;
        back_reg <= back_next;
        rem_reg  <= rem_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

`ifndef SYNTH
    a_done_after_sub: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(phase_reg == PH_SUB))
        else $error("divider done without a running division");

    a_no_restart_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_IDLE) |-> !start)
        else $error("divider started while busy");

    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> ({1'b0, rem_reg} < DIV_V))
        else $error("divider remainder out of range");
`endif

endmodule

### rtl/core/timing_wheel_timer_pool.sv
// hashed timing wheel over a pool of MAX_TIMERS timers and NUM_SLOTS slots
// s_ channel carries requests: add, refresh, cancel or tick, with timer id
// and timeout; m_ channel carries one expired timer id per result, tlast on
// the final expiry of a tick, ids in ascending order
// s_tready is high only while the block is idle
// cancel is done in the idle state; add and refresh use the shared divider
// that forms (timeout-1) / NUM_SLOTS with a reciprocal multiply, a back
// multiply and a subtract, then a ram write
// a tick scans the pool: the slot/rounds ram has one read port and the scan
// walks the pool one entry per cycle unless stalled; a tick with no expiry
// gives no result
// results go through an output register and a one-deep hold register, so a
// new request is taken while a result still waits; if m_tready stays low the
// scan stalls on an expiry while both registers are full
// reset clears the current slot and all armed flags; the ram needs no
// clearing pass since entries are used only for armed timers
module timing_wheel_timer_pool #(
    parameter int NUM_SLOTS  = ttw_pkg::DEF_NUM_SLOTS,
    parameter int MAX_TIMERS = ttw_pkg::DEF_MAX_TIMERS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // command [1:0], timer_id [7:2], timeout [23:8]
    input  logic [ttw_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // expired_id [5:0], zero [7:6]
    output logic [ttw_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast
);

    localparam int ID_W     = ttw_pkg::ID_W;
    localparam int TW       = ttw_pkg::TIMEOUT_W;
    localparam int RW       = ttw_pkg::ROUNDS_W;
    localparam int SLOT_W   = $clog2(NUM_SLOTS);
    localparam int AW       = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int IW       = $clog2(MAX_TIMERS + 1);
    localparam int ENTRY_W  = SLOT_W + RW;

    localparam logic [SLOT_W:0]   NS_V      = (SLOT_W+1)'(NUM_SLOTS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);
    localparam logic [ID_W:0]     MAXT_V    = (ID_W+1)'(MAX_TIMERS);
    localparam logic [IW-1:0]     SCAN_END  = IW'(MAX_TIMERS);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_WR    = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_FLUSH = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [SLOT_W-1:0]     cur_reg, cur_next;
    logic [MAX_TIMERS-1:0] active_reg, active_next;
    logic [AW-1:0]         id_reg, id_next;
    logic [IW-1:0]         scan_idx_reg, scan_idx_next;
    logic                  eval_valid_reg, eval_valid_next;
    logic [AW-1:0]         eval_idx_reg, eval_idx_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [AW-1:0]         pend_id_reg, pend_id_next;
    logic                  m_valid_reg, m_valid_next;
    logic [ID_W-1:0]       m_id_reg, m_id_next;
    logic                  m_last_reg, m_last_next;

    logic [ttw_pkg::CMD_W-1:0] s_cmd;
    logic [ID_W-1:0]           s_id;
    logic [TW-1:0]             s_timeout;
    logic                      s_accept;
    logic                      id_ok;
    logic [TW-1:0]             tm1;

    logic                      div_start;
    logic                      div_done;
    logic [TW-1:0]             div_quot;
    logic [SLOT_W-1:0]         div_rem;

    logic [SLOT_W:0]           slot_sum;
    logic [SLOT_W:0]           slot_wrap;
    logic [SLOT_W-1:0]         slot_new;
    logic [RW-1:0]             rounds_new;
    logic [SLOT_W-1:0]         cur_inc;

    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [ENTRY_W-1:0]        ram_wdata;
    logic                      ram_re;
    logic [ENTRY_W-1:0]        ram_rdata;
    logic [SLOT_W-1:0]         rd_slot;
    logic [RW-1:0]             rd_rounds;

    logic                      issuing;
    logic                      hit;
    logic                      expire;
    logic                      out_free;
    logic                      stall;
    logic                      out_load;
    logic [ID_W-1:0]           out_id;
    logic                      out_last;

    assign s_cmd     = s_tdata[1:0];
    assign s_id      = s_tdata[7:2];
    assign s_timeout = s_tdata[23:8];
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign id_ok     = ({1'b0, s_id} < MAXT_V);
    assign tm1       = (s_timeout == '0) ? '0 : s_timeout - 1'b1;

    ttw_div #(
        .DIVISOR (NUM_SLOTS),
        .SLOT_W  (SLOT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (tm1),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    // slot = (current + (t-1) mod N + 1) mod N, rounds saturate
    assign slot_sum   = {1'b0, cur_reg} + {1'b0, div_rem} + 1'b1;
    assign slot_wrap  = slot_sum - NS_V;
    assign slot_new   = (slot_sum >= NS_V) ? slot_wrap[SLOT_W-1:0] : slot_sum[SLOT_W-1:0];
    assign rounds_new = (div_quot[TW-1:RW] != '0) ? ttw_pkg::ROUNDS_MAX : div_quot[RW-1:0];
    assign cur_inc    = (cur_reg == LAST_SLOT) ? '0 : cur_reg + 1'b1;

    ttw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TIMERS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (scan_idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_slot   = ram_rdata[ENTRY_W-1:RW];
    assign rd_rounds = ram_rdata[RW-1:0];

    assign issuing  = (state_reg == ST_SCAN) && (scan_idx_reg < SCAN_END);
    assign hit      = (state_reg == ST_SCAN) && eval_valid_reg
                      && active_reg[eval_idx_reg] && (rd_slot == cur_reg);
    assign expire   = hit && (rd_rounds == '0);
    assign out_free = !m_valid_reg || m_tready;
    assign stall    = expire && pend_valid_reg && !out_free;

    always_comb begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        active_next     = active_reg;
        id_next         = id_reg;
        scan_idx_next   = scan_idx_reg;
        eval_valid_next = eval_valid_reg;
        eval_idx_next   = eval_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        div_start       = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = id_reg;
        ram_wdata       = {slot_new, rounds_new};
        ram_re          = 1'b0;
        out_load        = 1'b0;
        out_id          = ID_W'(pend_id_reg);
        out_last        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    unique case (s_cmd)
                        ttw_pkg::CMD_ADD: begin
                            if (id_ok) begin
                                id_next    = s_id[AW-1:0];
                                div_start  = 1'b1;
                                state_next = ST_DIV;
                            end
                        end
                        ttw_pkg::CMD_REFRESH: begin
                            if (id_ok && active_reg[s_id[AW-1:0]]) begin
                                id_next    = s_id[AW-1:0];
                                div_start  = 1'b1;
                                state_next = ST_DIV;
                            end
                        end
                        ttw_pkg::CMD_CANCEL: begin
                            if (id_ok) begin
                                active_next[s_id[AW-1:0]] = 1'b0;
                            end
                        end
                        ttw_pkg::CMD_TICK: begin
                            cur_next        = cur_inc;
                            scan_idx_next   = '0;
                            eval_valid_next = 1'b0;
                            state_next      = ST_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_WR;
                end
            end
            ST_WR: begin
                ram_we              = 1'b1;
                active_next[id_reg] = 1'b1;
                state_next          = ST_IDLE;
            end
            ST_SCAN: begin
                if (!stall) begin
                    ram_re          = issuing;
                    eval_valid_next = issuing;
                    eval_idx_next   = scan_idx_reg[AW-1:0];
                    if (issuing) begin
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                    if (hit && !expire) begin
                        ram_we    = 1'b1;
                        ram_waddr = eval_idx_reg;
                        ram_wdata = {rd_slot, rd_rounds - 1'b1};
                    end
                    if (expire) begin
                        active_next[eval_idx_reg] = 1'b0;
                        if (pend_valid_reg) begin
                            out_load = 1'b1;
                        end
                        pend_valid_next = 1'b1;
                        pend_id_next    = eval_idx_reg;
                    end
                    if (!issuing && !eval_valid_reg) begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_load        = 1'b1;
                    out_last        = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_id_next    = m_id_reg;
        m_last_next  = m_last_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
            m_id_next    = out_id;
            m_last_next  = out_last;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cur_reg        <= '0;
            active_reg     <= '0;
            scan_idx_reg   <= '0;
            eval_valid_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cur_reg        <= cur_next;
            active_reg     <= active_next;
            scan_idx_reg   <= scan_idx_next;
            eval_valid_reg <= eval_valid_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        id_reg       <= id_next;
        eval_idx_reg <= eval_idx_next;
        pend_id_reg  <= pend_id_next;
        m_id_reg     <= m_id_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(ttw_pkg::M_TDATA_W-ID_W){1'b0}}, m_id_reg};
    assign m_tlast  = m_last_reg;

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || m_tready))
        else $error("result register overwritten while waiting");

    a_pend_in_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> (state_reg == ST_SCAN || state_reg == ST_FLUSH))
        else $error("held expiry outside a tick scan");

    a_eval_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        eval_valid_reg |-> (state_reg == ST_SCAN))
        else $error("entry evaluation outside a tick scan");

    a_tick_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_cmd == ttw_pkg::CMD_TICK) |=>
        (cur_reg == (($past(cur_reg) == LAST_SLOT) ? '0 : $past(cur_reg) + 1'b1)))
        else $error("current slot not advanced by tick");

    a_write_arms: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WR) |=> active_reg[$past(id_reg)])
        else $error("timer not armed after write");
`endif

endmodule
